// ===== src/roicma_pkg.sv =====
// Shared constants for the region-of-interest center smoother.
`default_nettype none
package roicma_pkg;

   // Width of the frame size registers.
   localparam int FRAME_BITS = 13;

   // Width of every region result field.
   localparam int ROI_BITS = 14;

   // Configuration register map.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // Frame size after reset.
   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

endpackage
`default_nettype wire

// ===== src/roi_center_moving_average.sv =====
// Top level of the region-of-interest center smoother.
//
// Usage: each item on the req_ channel is a detected box given by two corners.
// The block stores the box midpoint in a window of the last WINDOW midpoints,
// averages the window with truncating division by the fill count, and returns
// one item on the rsp_ channel: a region centered on that average, plus a flag
// telling whether the previous average lay inside the box.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The csr_ channel writes frame_width (index 0) and frame_height (index 1);
// csr_ready is always high, and writes are meant to happen while the block idles.
// The two averages go one after the other through a single restoring divider that
// produces one quotient bit per cycle.
// req_stall stays high from acceptance until the result is loaded into the output
// register, so one item is in work at a time; a new item can be taken while a result waits.
// If the receiver stalls, the next finished result holds the block until it is taken.
// Reset (synchronous) empties the window, restores the frame size and drops any
// pending result.
`default_nettype none
module roi_center_moving_average
   import roicma_pkg::*;
#(
   parameter int WINDOW     = 12,
   parameter int COORD_BITS = 12
) (
   input  wire                        clock,
   input  wire                        reset,
   // Box items in.
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [COORD_BITS-1:0]      req_box_left_x,
   input  wire  [COORD_BITS-1:0]      req_box_top_y,
   input  wire  [COORD_BITS-1:0]      req_box_right_x,
   input  wire  [COORD_BITS-1:0]      req_box_bottom_y,
   // Region items out.
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [ROI_BITS-1:0] rsp_roi_x,
   output logic signed [ROI_BITS-1:0] rsp_roi_y,
   output logic signed [ROI_BITS-1:0] rsp_roi_width,
   output logic signed [ROI_BITS-1:0] rsp_roi_height,
   output logic                       rsp_prior_inside,
   // Register writes.
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [FRAME_BITS-1:0]      csr_data
);

   localparam int CNT_BITS  = $clog2(WINDOW + 1);
   localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_BITS  = COORD_BITS + $clog2(WINDOW);
   localparam int STEP_BITS = $clog2(SUM_BITS);
   localparam int EXT_BITS  = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 2;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_EXT    = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [FRAME_BITS-1:0]      frame_w_ff, frame_w_in;
   logic [FRAME_BITS-1:0]      frame_h_ff, frame_h_in;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [SLOT_BITS-1:0]       oldest_ff, oldest_in;
   logic [SUM_BITS-1:0]        sum_x_ff, sum_x_in;
   logic [SUM_BITS-1:0]        sum_y_ff, sum_y_in;
   logic [COORD_BITS-1:0]      lx_ff, ty_ff, rx_ff, by_ff;
   logic [COORD_BITS-1:0]      cx_ff, cy_ff;
   logic                       inside_ff, inside_in;
   logic [2*COORD_BITS-1:0]    rd_ff;
   logic [COORD_BITS-1:0]      ax_ff, ay_ff;
   logic [SUM_BITS-1:0]        div_q_ff, div_q_in;
   logic [CNT_BITS:0]          div_r_ff, div_r_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic                       axis_ff, axis_in;
   logic signed [EXT_BITS-1:0] ax_lo_ff, ax_hi_ff, ax_edge_ff;
   logic signed [EXT_BITS-1:0] ay_lo_ff, ay_hi_ff, ay_edge_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ROI_BITS-1:0] roi_x_ff, roi_y_ff, roi_w_ff, roi_h_ff;
   logic                       prior_ff;

   // Window storage: x midpoint in the upper half, y in the lower half.
   logic [2*COORD_BITS-1:0]    mem [WINDOW];

   logic                       accept;
   logic                       full;
   logic [CNT_BITS:0]          slot_raw;
   logic [SLOT_BITS-1:0]       wr_slot;
   logic [COORD_BITS-1:0]      old_x, old_y;
   logic [CNT_BITS:0]          rem_sh;
   logic                       q_bit;
   logic [SUM_BITS-1:0]        q_next;
   logic                       div_last;
   logic                       out_load;
   logic signed [EXT_BITS-1:0] ax_s, ay_s, hx, hy, mx, my, roi_x_full, roi_y_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign full      = (count_ff == CNT_BITS'(WINDOW));

   // Slot for a new midpoint: after the newest while the window is still filling, the oldest once full.
   always_comb begin
      slot_raw = (CNT_BITS+1)'(oldest_ff) + {1'b0, count_ff};
      if (slot_raw >= (CNT_BITS+1)'(WINDOW)) begin
         slot_raw = slot_raw - (CNT_BITS+1)'(WINDOW);
      end
      wr_slot = full ? oldest_ff : slot_raw[SLOT_BITS-1:0];
   end

   assign old_x = full ? rd_ff[2*COORD_BITS-1:COORD_BITS] : '0;
   assign old_y = full ? rd_ff[COORD_BITS-1:0] : '0;

   // One restoring divider step: one quotient bit per cycle.
   always_comb begin
      rem_sh = {div_r_ff[CNT_BITS-1:0], div_q_ff[SUM_BITS-1]};
      q_bit  = (rem_sh >= {1'b0, count_ff});
      q_next = {div_q_ff[SUM_BITS-2:0], q_bit};
   end
   assign div_last = (step_ff == STEP_BITS'(SUM_BITS - 1));

   // Half-extent: larger corner distance, limited by the far frame edge.
   always_comb begin
      ax_s = signed'({{(EXT_BITS-COORD_BITS){1'b0}}, ax_ff});
      ay_s = signed'({{(EXT_BITS-COORD_BITS){1'b0}}, ay_ff});
      mx   = (ax_lo_ff > ax_hi_ff) ? ax_lo_ff : ax_hi_ff;
      my   = (ay_lo_ff > ay_hi_ff) ? ay_lo_ff : ay_hi_ff;
      hx   = (ax_edge_ff < mx) ? ax_edge_ff : mx;
      hy   = (ay_edge_ff < my) ? ay_edge_ff : my;
      roi_x_full = ax_s - hx;
      roi_y_full = ay_s - hy;
   end

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer and running window state.
   always_comb begin
      state_in     = state_ff;
      frame_w_in   = frame_w_ff;
      frame_h_in   = frame_h_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      inside_in    = inside_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_w_in = csr_data;
            CSR_FRAME_HEIGHT: frame_h_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Flag from the average held before this item.
               inside_in = (count_ff == '0) ||
                           !(ax_ff < req_box_left_x || ay_ff > req_box_bottom_y ||
                             ax_ff > req_box_right_x || ay_ff < req_box_top_y);
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // Drop the oldest midpoint when full, add the new one.
            sum_x_in = sum_x_ff - SUM_BITS'(old_x) + SUM_BITS'(cx_ff);
            sum_y_in = sum_y_ff - SUM_BITS'(old_y) + SUM_BITS'(cy_ff);
            if (full) begin
               oldest_in = (oldest_ff == SLOT_BITS'(WINDOW - 1)) ? '0 : oldest_ff + 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            div_q_in = sum_x_in;
            div_r_in = '0;
            step_in  = '0;
            axis_in  = 1'b0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_q_in = q_next;
            div_r_in = q_bit ? rem_sh - {1'b0, count_ff} : rem_sh;
            step_in  = step_ff + 1'b1;
            if (div_last) begin
               step_in  = '0;
               div_r_in = '0;
               if (!axis_ff) begin
                  div_q_in = sum_y_ff;
                  axis_in  = 1'b1;
               end else begin
                  state_in = S_EXT;
               end
            end
         end
         S_EXT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_w_ff   <= FRAME_WIDTH_RESET;
         frame_h_ff   <= FRAME_HEIGHT_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_w_ff   <= frame_w_in;
         frame_h_ff   <= frame_h_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      div_q_ff  <= div_q_in;
      div_r_ff  <= div_r_in;
      step_ff   <= step_in;
      axis_ff   <= axis_in;
      if (accept) begin
         lx_ff <= req_box_left_x;
         ty_ff <= req_box_top_y;
         rx_ff <= req_box_right_x;
         by_ff <= req_box_bottom_y;
         cx_ff <= COORD_BITS'(({1'b0, req_box_left_x} + {1'b0, req_box_right_x}) >> 1);
         cy_ff <= COORD_BITS'(({1'b0, req_box_top_y} + {1'b0, req_box_bottom_y}) >> 1);
      end
      if (state_ff == S_DIV && div_last) begin
         if (!axis_ff) begin
            ax_ff <= q_next[COORD_BITS-1:0];
         end else begin
            ay_ff <= q_next[COORD_BITS-1:0];
         end
      end
      if (state_ff == S_EXT) begin
         ax_lo_ff   <= ax_s - signed'({{(EXT_BITS-COORD_BITS){1'b0}}, lx_ff});
         ax_hi_ff   <= signed'({{(EXT_BITS-COORD_BITS){1'b0}}, rx_ff}) - ax_s;
         ax_edge_ff <= signed'({{(EXT_BITS-FRAME_BITS){1'b0}}, frame_w_ff}) - ax_s;
         ay_lo_ff   <= ay_s - signed'({{(EXT_BITS-COORD_BITS){1'b0}}, ty_ff});
         ay_hi_ff   <= signed'({{(EXT_BITS-COORD_BITS){1'b0}}, by_ff}) - ay_s;
         ay_edge_ff <= signed'({{(EXT_BITS-FRAME_BITS){1'b0}}, frame_h_ff}) - ay_s;
      end
      if (out_load) begin
         roi_x_ff <= roi_x_full[ROI_BITS-1:0];
         roi_y_ff <= roi_y_full[ROI_BITS-1:0];
         roi_w_ff <= {hx[ROI_BITS-2:0], 1'b0};
         roi_h_ff <= {hy[ROI_BITS-2:0], 1'b0};
         prior_ff <= inside_ff;
      end
   end

   // Window memory: read the oldest entry on acceptance, write the new one after.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[oldest_ff];
      end
      if (state_ff == S_UPDATE) begin
         mem[wr_slot] <= {cx_ff, cy_ff};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roi_x        = roi_x_ff;
   assign rsp_roi_y        = roi_y_ff;
   assign rsp_roi_width    = roi_w_ff;
   assign rsp_roi_height   = roi_h_ff;
   assign rsp_prior_inside = prior_ff;

endmodule
`default_nettype wire

// ===== src/roicma_checker.sv =====
// Port-level checks for the region-of-interest center smoother, with its bind.
`default_nettype none
module roicma_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_stall,
   input wire rsp_valid,
   input wire rsp_stall
);

   // Reset drops any pending result.
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Reset leaves the block ready for an item.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req_stall high after reset");

   // One item at a time: acceptance closes the input.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while busy");

   // No result can appear in the cycle right after an item is taken.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

bind roi_center_moving_average roicma_checker u_roicma_checker (.*);
`default_nettype wire
